[hw/rtl/scfk_pkg.sv]
// ----------------------------------------------------------------------------
// scfk_pkg
// Types, constants and helper functions shared by the serial chain forward
// kinematics core and its CORDIC unit.
// ----------------------------------------------------------------------------
`default_nettype none

package scfk_pkg;

  localparam int ANG_W            = 16;
  localparam int ROT_W            = 18;
  localparam int POS_W            = 32;
  localparam int LEN_W            = 12;
  localparam int PROD_W           = 2 * ROT_W;
  localparam int ACC_W            = PROD_W + 2;
  localparam int ATAN_COUNT       = 24;
  localparam int ANGLE_WIDTH_DEF  = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam logic [LEN_W-1:0] LEN_RESET = 12'd100;

  typedef logic signed [ROT_W-1:0] rot_t;
  typedef logic signed [POS_W-1:0] pos_t;

  localparam rot_t ONE_Q16  = 18'sd65536;
  localparam rot_t ZERO_Q16 = 18'sd0;

  localparam logic signed [ACC_W-1:0] ROT_MAX = ACC_W'(131071);
  localparam logic signed [ACC_W-1:0] ROT_MIN = -ACC_W'(131072);

  typedef struct packed {
    logic done;
    rot_t cos_v;
    rot_t sin_v;
  } scfk_cs_t;

  function automatic logic [29:0] scfk_atan(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:    v = 30'd536870912;
      5'd1:    v = 30'd316933406;
      5'd2:    v = 30'd167458907;
      5'd3:    v = 30'd85004756;
      5'd4:    v = 30'd42667331;
      5'd5:    v = 30'd21354465;
      5'd6:    v = 30'd10680350;
      5'd7:    v = 30'd5340245;
      5'd8:    v = 30'd2670163;
      5'd9:    v = 30'd1335087;
      5'd10:   v = 30'd667544;
      5'd11:   v = 30'd333772;
      5'd12:   v = 30'd166886;
      5'd13:   v = 30'd83443;
      5'd14:   v = 30'd41722;
      5'd15:   v = 30'd20861;
      5'd16:   v = 30'd10430;
      5'd17:   v = 30'd5215;
      5'd18:   v = 30'd2608;
      5'd19:   v = 30'd1304;
      5'd20:   v = 30'd652;
      5'd21:   v = 30'd326;
      5'd22:   v = 30'd163;
      5'd23:   v = 30'd81;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  function automatic rot_t sat_rot(input logic signed [ACC_W-1:0] v);
    rot_t r;
    if (v > ROT_MAX) begin
      r = rot_t'(ROT_MAX);
    end else if (v < ROT_MIN) begin
      r = rot_t'(ROT_MIN);
    end else begin
      r = rot_t'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/scfk_if.sv]
// ----------------------------------------------------------------------------
// scfk_if
// Valid/ready channels for segment angles in and end positions out.
// ----------------------------------------------------------------------------
`default_nettype none

interface scfk_seg_if import scfk_pkg::*;;
  logic              valid;
  logic              ready;
  logic [ANG_W-1:0]  angle_x;
  logic [ANG_W-1:0]  angle_y;
  logic [ANG_W-1:0]  angle_z;
  logic              first_segment;
  logic              final_segment;

  modport source (output valid, angle_x, angle_y, angle_z, first_segment, final_segment,
                  input ready);
  modport sink   (input valid, angle_x, angle_y, angle_z, first_segment, final_segment,
                  output ready);
endinterface

interface scfk_pos_if import scfk_pkg::*;;
  logic        valid;
  logic        ready;
  pos_t        end_x;
  pos_t        end_y;
  pos_t        end_z;
  logic        is_end_effector;

  modport source (output valid, end_x, end_y, end_z, is_end_effector, input ready);
  modport sink   (input valid, end_x, end_y, end_z, is_end_effector, output ready);
endinterface

`default_nettype wire

[hw/rtl/scfk_cordic.sv]
// ----------------------------------------------------------------------------
// scfk_cordic
// Iterative rotation-mode CORDIC: one binary angle in, Q2.16 cosine and sine
// out, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module scfk_cordic import scfk_pkg::*; #(
  parameter int ANGLE_WIDTH  = ANGLE_WIDTH_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [ANG_W-1:0] angle,
  output scfk_cs_t         res
);

  localparam int NSTEP = (CORDIC_STEPS < ATAN_COUNT) ? CORDIC_STEPS : ATAN_COUNT;
  localparam logic [31:0] PMASK = 32'hFFFF_FFFF << (32 - ANGLE_WIDTH);
  localparam logic signed [33:0] X0 = 34'sd652032874;
  localparam logic signed [32:0] QTR = 33'sd1073741824;
  localparam logic signed [32:0] HALF = 33'sd2147483648;

  logic               busy;
  logic [4:0]         step;
  logic signed [33:0] x;
  logic signed [33:0] y;
  logic signed [32:0] z;
  logic               flip;

  logic [31:0]        ph;
  logic signed [32:0] z0;
  logic signed [32:0] zf;
  logic               flip0;
  logic signed [33:0] dx;
  logic signed [33:0] dy;
  logic signed [32:0] at;
  logic signed [33:0] xr;
  logic signed [33:0] yr;

  always_comb begin
    ph    = {angle, 16'h0000} & PMASK;
    z0    = {ph[31], ph};
    flip0 = 1'b0;
    zf    = z0;
    if (z0 > QTR) begin
      zf    = z0 - HALF;
      flip0 = 1'b1;
    end else if (z0 < -QTR) begin
      zf    = z0 + HALF;
      flip0 = 1'b1;
    end
    dx = y >>> step;
    dy = x >>> step;
    at = {3'b000, scfk_atan(step)};
    xr = (x + 34'sd8192) >>> 14;
    yr = (y + 34'sd8192) >>> 14;
    if (flip) begin
      xr = -xr;
      yr = -yr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      res.done <= 1'b0;
    end else if (start) begin
      x        <= X0;
      y        <= '0;
      z        <= zf;
      flip     <= flip0;
      step     <= '0;
      busy     <= 1'b1;
      res.done <= 1'b0;
    end else if (busy) begin
      if (step < 5'(NSTEP)) begin
        if (z >= 0) begin
          x <= x - dx;
          y <= y + dy;
          z <= z - at;
        end else begin
          x <= x + dx;
          y <= y - dy;
          z <= z + at;
        end
        step     <= step + 5'd1;
        res.done <= 1'b0;
      end else begin
        res.cos_v <= sat_rot(ACC_W'(xr));
        res.sin_v <= sat_rot(ACC_W'(yr));
        res.done  <= 1'b1;
        busy      <= 1'b0;
      end
    end else begin
      res.done <= 1'b0;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/serial_chain_forward_kinematics_core.sv]
// ----------------------------------------------------------------------------
// serial_chain_forward_kinematics_core
// Segment-by-segment forward kinematics of a serial chain with ZYX Euler
// joints, accumulated rotation in Q2.16 and saturating 24.8 positions.
// ----------------------------------------------------------------------------
// A segment word is processed by the single CORDIC unit, run once per
// angle, and by the single 18x18 multiplier, which forms the three 3x3
// products one entry at a time and then the three position steps. A new
// segment is taken only after the previous one has been handed to the output
// register.
`default_nettype none

module serial_chain_forward_kinematics_core import scfk_pkg::*; #(
  parameter int ANGLE_WIDTH  = ANGLE_WIDTH_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  scfk_seg_if.sink         seg,
  scfk_pos_if.source       pos,
  input  logic             cfg_wr_en,
  input  logic [LEN_W-1:0] cfg_wr_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_CSTART, S_CWAIT, S_LOAD, S_MUL, S_COPY, S_POS, S_OUT
  } state_t;

  state_t            state;
  logic [LEN_W-1:0]  seg_len;
  logic [ANG_W-1:0]  ang [3];
  logic              fin;
  logic [1:0]        ang_sel;
  rot_t              c_v [3];
  rot_t              s_v [3];
  rot_t              mat_a [9];
  rot_t              mat_b [9];
  rot_t              tmp [9];
  rot_t              rot [9];
  pos_t              pacc [3];
  logic [1:0]        row;
  logic [1:0]        col;
  logic [2:0]        k;
  logic [1:0]        pnum;
  logic [2:0]        cnt;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;

  scfk_cs_t          cs;
  logic [1:0]        kk;
  logic [1:0]        pr;
  logic [1:0]        pw;
  logic [3:0]        a_idx;
  logic [3:0]        b_idx;
  logic [3:0]        o_idx;
  rot_t              mul_a;
  rot_t              mul_b;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [PROD_W:0]   step_r;
  logic signed [POS_W:0]    psum;
  pos_t              psat;

  scfk_cordic #(
    .ANGLE_WIDTH  (ANGLE_WIDTH),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_CSTART),
    .angle (ang[ang_sel]),
    .res   (cs)
  );

  assign seg.ready = (state == S_IDLE);

  always_comb begin
    kk    = (k < 3'd3) ? k[1:0] : 2'd0;
    pr    = (cnt < 3'd3) ? cnt[1:0] : 2'd0;
    pw    = 2'(cnt - 3'd1);
    a_idx = {2'b00, row} * 4'd3 + {2'b00, kk};
    b_idx = {2'b00, kk} * 4'd3 + {2'b00, col};
    o_idx = {2'b00, row} * 4'd3 + {2'b00, col};
    if (state == S_POS) begin
      mul_a = rot[{2'b00, pr} * 4'd3 + 4'd2];
      mul_b = rot_t'({{(ROT_W - LEN_W){1'b0}}, seg_len});
    end else begin
      mul_a = mat_a[a_idx];
      mul_b = mat_b[b_idx];
    end
    rnd    = (acc + ACC_W'(32768)) >>> 16;
    step_r = ((PROD_W + 1)'(prod) + (PROD_W + 1)'(128)) >>> 8;
    psum   = (POS_W + 1)'(pacc[pw]) + (POS_W + 1)'(step_r);
    if (psum > (POS_W + 1)'(33'sh0_7FFF_FFFF)) begin
      psat = {1'b0, {(POS_W - 1){1'b1}}};
    end else if (psum < -(POS_W + 1)'(33'sh0_8000_0000)) begin
      psat = {1'b1, {(POS_W - 1){1'b0}}};
    end else begin
      psat = pos_t'(psum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      seg_len   <= LEN_RESET;
      pos.valid <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        rot[i] <= (i % 4 == 0) ? ONE_Q16 : ZERO_Q16;
      end
      for (int i = 0; i < 3; i++) begin
        pacc[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        seg_len <= cfg_wr_data;
      end
      if (pos.valid && pos.ready && state != S_OUT) begin
        pos.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (seg.valid) begin
            ang[0]  <= seg.angle_x;
            ang[1]  <= seg.angle_y;
            ang[2]  <= seg.angle_z;
            fin     <= seg.final_segment;
            ang_sel <= 2'd0;
            if (seg.first_segment) begin
              for (int i = 0; i < 9; i++) begin
                rot[i] <= (i % 4 == 0) ? ONE_Q16 : ZERO_Q16;
              end
              for (int i = 0; i < 3; i++) begin
                pacc[i] <= '0;
              end
            end
            state <= S_CSTART;
          end
        end
        S_CSTART: begin
          state <= S_CWAIT;
        end
        S_CWAIT: begin
          if (cs.done) begin
            c_v[ang_sel] <= cs.cos_v;
            s_v[ang_sel] <= cs.sin_v;
            if (ang_sel == 2'd2) begin
              state <= S_LOAD;
            end else begin
              ang_sel <= ang_sel + 2'd1;
              state   <= S_CSTART;
            end
          end
        end
        S_LOAD: begin
          mat_a[0] <= c_v[2];  mat_a[1] <= -s_v[2];  mat_a[2] <= ZERO_Q16;
          mat_a[3] <= s_v[2];  mat_a[4] <= c_v[2];   mat_a[5] <= ZERO_Q16;
          mat_a[6] <= ZERO_Q16; mat_a[7] <= ZERO_Q16; mat_a[8] <= ONE_Q16;
          mat_b[0] <= c_v[1];  mat_b[1] <= ZERO_Q16; mat_b[2] <= s_v[1];
          mat_b[3] <= ZERO_Q16; mat_b[4] <= ONE_Q16;  mat_b[5] <= ZERO_Q16;
          mat_b[6] <= -s_v[1]; mat_b[7] <= ZERO_Q16; mat_b[8] <= c_v[1];
          pnum  <= 2'd0;
          row   <= 2'd0;
          col   <= 2'd0;
          k     <= 3'd0;
          state <= S_MUL;
        end
        S_MUL: begin
          if (k < 3'd3) begin
            prod <= mul_a * mul_b;
          end
          if (k == 3'd1) begin
            acc <= ACC_W'(prod);
          end else if (k == 3'd2 || k == 3'd3) begin
            acc <= acc + ACC_W'(prod);
          end
          if (k == 3'd4) begin
            tmp[o_idx] <= sat_rot(rnd);
            k <= 3'd0;
            if (col == 2'd2) begin
              col <= 2'd0;
              if (row == 2'd2) begin
                row   <= 2'd0;
                state <= S_COPY;
              end else begin
                row <= row + 2'd1;
              end
            end else begin
              col <= col + 2'd1;
            end
          end else begin
            k <= k + 3'd1;
          end
        end
        S_COPY: begin
          case (pnum)
            2'd0: begin
              mat_a <= tmp;
              mat_b[0] <= ONE_Q16;  mat_b[1] <= ZERO_Q16; mat_b[2] <= ZERO_Q16;
              mat_b[3] <= ZERO_Q16; mat_b[4] <= c_v[0];   mat_b[5] <= -s_v[0];
              mat_b[6] <= ZERO_Q16; mat_b[7] <= s_v[0];   mat_b[8] <= c_v[0];
              pnum  <= 2'd1;
              state <= S_MUL;
            end
            2'd1: begin
              mat_a <= rot;
              mat_b <= tmp;
              pnum  <= 2'd2;
              state <= S_MUL;
            end
            default: begin
              rot   <= tmp;
              cnt   <= 3'd0;
              state <= S_POS;
            end
          endcase
        end
        S_POS: begin
          if (cnt < 3'd3) begin
            prod <= mul_a * mul_b;
          end
          if (cnt != 3'd0) begin
            pacc[pw] <= psat;
          end
          if (cnt == 3'd3) begin
            state <= S_OUT;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        S_OUT: begin
          if (!pos.valid || pos.ready) begin
            pos.valid           <= 1'b1;
            pos.end_x           <= pacc[0];
            pos.end_y           <= pacc[1];
            pos.end_z           <= pacc[2];
            pos.is_end_effector <= fin;
            state               <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/scfk_chk.sv]
// ----------------------------------------------------------------------------
// scfk_chk
// Port-level checks for the forward kinematics core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module scfk_chk import scfk_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input pos_t out_end_x
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_end_x))
    else $error("result word changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second segment word taken while one is in flight");

  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("core not idle after reset");

endmodule

bind serial_chain_forward_kinematics_core scfk_chk u_scfk_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (seg.valid),
  .in_ready  (seg.ready),
  .out_valid (pos.valid),
  .out_ready (pos.ready),
  .out_end_x (pos.end_x)
);

`default_nettype wire
